[design/lrtd_pkg.sv]
// ----------------------------------------------------------------------------
// lrtd_pkg: shared types and constants of the LZSS RGB triplet decoder
// Holds the channel payload types, the controller to datapath command and
// status groups, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package lrtd_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_WINDOW_DEPTH = 16384;
    localparam int DEF_MAX_SIDE     = 4096;

    // Configuration port layout.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_VAL_W  = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // A distance reaches at most 4096 pixels, which is 12288 bytes.
    localparam int DIST_W = 14;
    // A run copies at most 16 pixels, which is 48 bytes.
    localparam int REPS_W = 6;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_image;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       image_done;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // Restart the image before this byte is used.
        logic put_lit;     // Emit the input byte as a literal if it still fits.
        logic load_low;    // Keep the input byte as the low half of a reference.
        logic start_copy;  // Decode the reference into distance and run length.
        logic rd_first;    // Issue the first history read of a copy.
        logic put_copy;    // Emit the history byte that was read.
        logic rd_next;     // Issue the history read for the next copy byte.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // Output count has reached the image size.
        logic lt3;         // Fewer than three bytes remain.
        logic full_clr;    // Same as full, for a freshly restarted image.
        logic lt3_clr;     // Same as lt3, for a freshly restarted image.
        logic out_space;   // The output queue can take one more result.
        logic copy_last;   // The pending copy byte ends the run.
    } sts_t;

endpackage

[design/lrtd_ram.sv]
// ----------------------------------------------------------------------------
// lrtd_ram: simple dual-port RAM with a registered read
// One write port and one read port; the read data register holds its value
// while no read is issued.
// ----------------------------------------------------------------------------
module lrtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/lrtd_dpath.sv]
// ----------------------------------------------------------------------------
// lrtd_dpath: datapath of the LZSS RGB triplet decoder
// Configuration registers, image size, output counter, history window,
// copy address generation and a two-entry output queue.
// ----------------------------------------------------------------------------
module lrtd_dpath import lrtd_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  in_item_t              in_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CFG_MAX  = (2 ** CFG_VAL_W) - 1;
    localparam int EFF_SIDE = (MAX_SIDE < CFG_MAX) ? MAX_SIDE : CFG_MAX;
    localparam int SIDE_W   = $clog2(EFF_SIDE + 1);
    localparam int TOTAL_W  = $clog2(EFF_SIDE * EFF_SIDE * 3 + 1);
    localparam int AW       = $clog2(WINDOW_DEPTH);
    localparam int SUB_W    = ((AW > DIST_W) ? AW : DIST_W) + 1;
    localparam int ZW       = (TOTAL_W > DIST_W) ? TOTAL_W : DIST_W;

    // Clamp a configured side to the largest supported one.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_VAL_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (int'(v) > EFF_SIDE) begin
            r = SIDE_W'(EFF_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    // Advance a window pointer with wrap at the window depth.
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(WINDOW_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    logic [CFG_VAL_W-1:0] width_reg, height_reg;
    logic [CFG_VAL_W-1:0] width_eff, height_eff;
    logic [TOTAL_W-1:0]   total_reg, total_next, prod;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    logic [TOTAL_W-1:0]   oc_reg, oc_next, oc_eff, oc_inc, oc_reg_inc;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next, wr_eff;
    logic [7:0]           low_reg;
    logic [DIST_W-1:0]    dist_reg, dist_p1;
    logic [REPS_W-1:0]    reps_reg, reps_p1;
    logic [15:0]          ref_word;
    logic [SUB_W-1:0]     src_diff;
    logic [AW-1:0]        raddr_first, raddr, src_addr_reg;
    logic                 zero_reg, zero_next, ram_re;
    logic [7:0]           ram_q;

    logic                 push_lit, push;
    out_item_t            push_item;
    out_item_t            out_reg, skid_reg;
    logic [1:0]           cnt_reg;
    logic                 pop;

    // Configuration port: writes update the register and the image size.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb begin
        width_eff  = width_reg;
        height_eff = height_reg;
        if (cfg_wr && (cfg_idx == REG_IMAGE_WIDTH)) begin
            width_eff = pwdata[CFG_VAL_W-1:0];
        end
        if (cfg_wr && (cfg_idx == REG_IMAGE_HEIGHT)) begin
            height_eff = pwdata[CFG_VAL_W-1:0];
        end
    end

    assign prod       = TOTAL_W'(clamp_side(width_eff)) * TOTAL_W'(clamp_side(height_eff));
    assign total_next = prod + (prod << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_VAL_W'(1);
            height_reg <= CFG_VAL_W'(1);
            total_reg  <= TOTAL_W'(3);
        end else if (cfg_wr) begin
            width_reg  <= width_eff;
            height_reg <= height_eff;
            total_reg  <= total_next;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Output count and window pointer, restarted at a new image.
    assign oc_eff     = cmd.clear ? '0 : oc_reg;
    assign wr_eff     = cmd.clear ? '0 : wr_ptr_reg;
    assign oc_inc     = oc_eff + 1'b1;
    assign oc_reg_inc = oc_reg + 1'b1;

    assign push_lit = cmd.put_lit && (oc_eff < total_reg);
    assign push     = push_lit || cmd.put_copy;

    assign oc_next     = push ? oc_inc : oc_eff;
    assign wr_ptr_next = push ? wrap_inc(wr_eff) : wr_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oc_reg     <= '0;
            wr_ptr_reg <= '0;
        end else begin
            oc_reg     <= oc_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Status toward the controller; it depends on registers only.
    assign sts.full      = oc_reg >= total_reg;
    assign sts.lt3       = (total_reg - oc_reg) < TOTAL_W'(3);
    assign sts.full_clr  = total_reg == '0;
    assign sts.lt3_clr   = total_reg < TOTAL_W'(3);
    assign sts.out_space = cnt_reg != 2'd2;
    assign sts.copy_last = (reps_reg == REPS_W'(1)) || (oc_reg_inc >= total_reg);

    // Back-reference decode: run length and distance, both in bytes.
    assign ref_word = {in_item.in_byte, low_reg};
    assign dist_p1  = DIST_W'(ref_word[15:4]) + 1'b1;
    assign reps_p1  = REPS_W'(ref_word[3:0]) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg <= '0;
        end else if (cmd.clear) begin
            low_reg <= '0;
        end else if (cmd.load_low) begin
            low_reg <= in_item.in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_copy) begin
            dist_reg <= dist_p1 + (dist_p1 << 1);
            reps_reg <= reps_p1 + (reps_p1 << 1);
        end else if (cmd.put_copy) begin
            reps_reg <= reps_reg - 1'b1;
        end
    end

    // Copy source address: the first one is the write pointer minus the
    // distance modulo the window depth, the later ones step by one.
    assign src_diff    = SUB_W'(wr_ptr_reg) - SUB_W'(dist_reg);
    assign raddr_first = src_diff[SUB_W-1] ? AW'(src_diff + SUB_W'(WINDOW_DEPTH))
                                           : AW'(src_diff);
    assign raddr       = cmd.rd_first ? raddr_first : src_addr_reg;
    assign ram_re      = cmd.rd_first || cmd.rd_next;

    // A source position before the start of the image reads as zero.
    assign zero_next = cmd.rd_first ? (ZW'(oc_reg) < ZW'(dist_reg))
                                    : (ZW'(oc_inc) < ZW'(dist_reg));

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            src_addr_reg <= wrap_inc(raddr);
            zero_reg     <= zero_next;
        end
    end

    lrtd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (push),
        .waddr (wr_eff),
        .wdata (push_item.out_byte),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Result assembled for the output queue.
    always_comb begin
        if (push_lit) begin
            push_item.out_byte    = in_item.in_byte;
            push_item.last_of_run = 1'b1;
        end else begin
            push_item.out_byte    = zero_reg ? 8'h00 : ram_q;
            push_item.last_of_run = sts.copy_last;
        end
        push_item.image_done = oc_inc >= total_reg;
    end

    // Two-entry output queue: the head is presented, the second entry
    // lets the block keep working while the head waits.
    assign m_valid = cnt_reg != 2'd0;
    assign m_data  = out_reg;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    out_reg <= push_item;
                end else begin
                    skid_reg <= push_item;
                end
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    out_reg <= push_item;
                end else begin
                    out_reg  <= skid_reg;
                    skid_reg <= push_item;
                end
            end
            2'b01: begin
                out_reg <= skid_reg;
            end
            default: begin
                out_reg <= out_reg;
            end
        endcase
    end

endmodule

[design/lrtd_ctrl.sv]
// ----------------------------------------------------------------------------
// lrtd_ctrl: controller of the LZSS RGB triplet decoder
// Parses the token stream (flag bits, literal bytes, reference halves) and
// sequences the history copy of each back-reference.
// ----------------------------------------------------------------------------
module lrtd_ctrl import lrtd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  sts_t     sts,
    output cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_CP   = 3'b100
    } state_t;

    typedef enum logic [3:0] {
        PH_TOKEN  = 4'b0001,
        PH_LIT2   = 4'b0010,
        PH_LIT1   = 4'b0100,
        PH_REF_HI = 4'b1000
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next, ph;
    logic [8:0] flag_reg, flag_next, fs;
    logic       stop_reg, stop_next, st;
    logic       accept, full, lt3;

    // Input bytes are taken while idle and the output queue has room.
    assign s_ready = (state_reg == S_IDLE) && sts.out_space;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        stop_next  = stop_reg;
        fs         = s_data.new_image ? 9'd0 : flag_reg;
        ph         = s_data.new_image ? PH_TOKEN : phase_reg;
        st         = s_data.new_image ? 1'b0 : stop_reg;
        full       = s_data.new_image ? sts.full_clr : sts.full;
        lt3        = s_data.new_image ? sts.lt3_clr : sts.lt3;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.clear  = s_data.new_image;
                    flag_next  = fs;
                    phase_next = ph;
                    stop_next  = st;
                    if (!st) begin
                        unique case (ph)
                            PH_TOKEN: begin
                                // An exhausted flag byte makes this byte the next flags.
                                if (!full) begin
                                    if (fs[7:0] == 8'd0) begin
                                        flag_next = {s_data.in_byte, 1'b1};
                                    end else begin
                                        flag_next = {fs[7:0], 1'b0};
                                        if (fs[8]) begin
                                            if (lt3) begin
                                                stop_next = 1'b1;
                                            end else begin
                                                cmd.put_lit = 1'b1;
                                                phase_next  = PH_LIT2;
                                            end
                                        end else begin
                                            cmd.load_low = 1'b1;
                                            phase_next   = PH_REF_HI;
                                        end
                                    end
                                end
                            end
                            PH_LIT2: begin
                                cmd.put_lit = 1'b1;
                                phase_next  = PH_LIT1;
                            end
                            PH_LIT1: begin
                                cmd.put_lit = 1'b1;
                                phase_next  = PH_TOKEN;
                            end
                            PH_REF_HI: begin
                                cmd.start_copy = 1'b1;
                                phase_next     = PH_TOKEN;
                                state_next     = S_RD;
                            end
                            default: begin
                                phase_next = PH_TOKEN;
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                // A copy that starts at the image end produces nothing.
                if (sts.full) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_CP;
                end
            end
            S_CP: begin
                // One copy byte per cycle while the queue has room, next read alongside.
                if (sts.out_space) begin
                    cmd.put_copy = 1'b1;
                    if (sts.copy_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TOKEN;
            flag_reg  <= '0;
            stop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

[design/lzss_rgb_triplet_decoder_top.sv]
// ----------------------------------------------------------------------------
// lzss_rgb_triplet_decoder_top: streaming LZSS decoder for 3-byte pixels
// Decodes one compressed byte per input transaction into B G R bytes,
// copying back-references from a history window, capped at the image size.
//
//   Channel   Direction  Signals                         Payload
//   s_        in         s_valid, s_ready, s_data        in_byte, new_image
//   m_        out        m_valid, m_ready, m_data        out_byte, last_of_run,
//                                                        image_done
//   APB       in/out     psel, penable, pwrite, paddr,   image_width @ 0x0,
//                        pwdata, prdata, pready          image_height @ 0x4
//
// Flag, literal and low reference bytes are taken only while no copy runs. A
// reference high byte is decoded into distance and run length n (n up to 48),
// then the first window read is issued, then one byte per cycle comes from the
// single-read-port history RAM while the output queue has room.
// Reset needs no window clearing: only bytes written since the image began
// are ever read. A two-entry output queue absorbs short output stalls.
// ----------------------------------------------------------------------------
module lzss_rgb_triplet_decoder_top import lrtd_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cmd_t cmd;
    sts_t sts;

    // Token parser and copy sequencer.
    lrtd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Counters, history window, configuration and output queue.
    lrtd_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_SIDE     (MAX_SIDE)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .in_item (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

endmodule

[tb/sv/tb_lzss_rgb_triplet_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_rgb_triplet_decoder_top: self-checking bench of the triplet decoder
// Feeds compressed bytes through the input channel and checks every decoded
// byte against a cycle-free decoder kept in a scoreboard. A directed part
// covers size limits, a full image, a literal that no longer fits and size
// changes inside a token, then random images run under random idling.
// ----------------------------------------------------------------------------
module tb_lzss_rgb_triplet_decoder_top;
    import lrtd_pkg::*;

    localparam int WINDOW_BYTES  = DEF_WINDOW_DEPTH;
    localparam int SIDE_LIMIT    = DEF_MAX_SIDE;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 150;

    // Where the decoder stands inside the token stream.
    typedef enum logic [1:0] {
        TOKEN_START,
        LIT_TWO_LEFT,
        LIT_ONE_LEFT,
        REF_HIGH
    } token_phase_t;

    // Decoder state mirror plus the queue of bytes still to come out.
    class triplet_scoreboard;
        bit [7:0]     history [WINDOW_BYTES];
        bit [8:0]     flag_bits;
        token_phase_t phase;
        bit [7:0]     low_byte;
        int unsigned  produced;
        bit           halted;
        bit [12:0]    width_cfg;
        bit [12:0]    height_cfg;
        out_item_t    expected_bytes[$];
        out_item_t    run_bytes[$];
        int           mismatches;

        function new();
            restart();
            width_cfg  = 13'd1;
            height_cfg = 13'd1;
            mismatches = 0;
        endfunction

        function void restart();
            flag_bits = '0;
            phase     = TOKEN_START;
            low_byte  = '0;
            produced  = 0;
            halted    = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [12:0] value);
            if (idx == REG_IMAGE_WIDTH) begin
                width_cfg = value;
            end else begin
                height_cfg = value;
            end
        endfunction

        function int unsigned clamp_side(bit [12:0] v);
            return (v > SIDE_LIMIT) ? SIDE_LIMIT : v;
        endfunction

        function int unsigned image_bytes();
            return clamp_side(width_cfg) * clamp_side(height_cfg) * 3;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Writes one byte to the history and queues it, unless the image is full.
        function void emit(bit [7:0] b, int unsigned total);
            out_item_t r;
            if (produced >= total) return;
            history[produced % WINDOW_BYTES] = b;
            produced++;
            r.out_byte    = b;
            r.last_of_run = 1'b0;
            r.image_done  = (produced >= total);
            run_bytes.push_back(r);
        endfunction

        // Called for every accepted input transaction.
        function void decode_byte(in_item_t item);
            bit [7:0]    b;
            bit [15:0]   word;
            bit [7:0]    src;
            bit          is_literal;
            int unsigned total;
            int unsigned reps;
            int unsigned distance;
            int unsigned i;
            out_item_t   r;
            b = item.in_byte;
            run_bytes.delete();
            if (item.new_image) restart();
            if (halted) return;
            total = image_bytes();
            case (phase)
                TOKEN_START: begin
                    if (produced >= total) return;
                    // An empty flag register means this byte is the next flag byte.
                    if (flag_bits[7:0] == 8'h00) begin
                        flag_bits = {b, 1'b1};
                        return;
                    end
                    is_literal = flag_bits[8];
                    flag_bits  = flag_bits << 1;
                    if (is_literal) begin
                        if (total - produced < 3) begin
                            halted = 1'b1;
                            return;
                        end
                        emit(b, total);
                        phase = LIT_TWO_LEFT;
                    end else begin
                        low_byte = b;
                        phase    = REF_HIGH;
                    end
                end
                LIT_TWO_LEFT: begin
                    emit(b, total);
                    phase = LIT_ONE_LEFT;
                end
                LIT_ONE_LEFT: begin
                    emit(b, total);
                    phase = TOKEN_START;
                end
                default: begin
                    // Byte-wise copy so that overlapping runs repeat the pattern.
                    word     = {b, low_byte};
                    reps     = (word[3:0] + 1) * 3;
                    distance = (word[15:4] + 1) * 3;
                    for (i = 0; i < reps && produced < total; i++) begin
                        src = (produced >= distance) ?
                              history[(produced - distance) % WINDOW_BYTES] : 8'h00;
                        emit(src, total);
                    end
                    phase = TOKEN_START;
                end
            endcase
            if (run_bytes.size() > 0) begin
                r = run_bytes.pop_back();
                r.last_of_run = 1'b1;
                run_bytes.push_back(r);
            end
            foreach (run_bytes[k]) expected_bytes.push_back(run_bytes[k]);
        endfunction

        // Called for every accepted result transaction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: out_byte %0h", got.out_byte);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b",
                       want.last_of_run, got.last_of_run);
                mismatches++;
            end
            if (got.image_done !== want.image_done) begin
                $error("image_done: expected %0b, got %0b",
                       want.image_done, got.image_done);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    triplet_scoreboard sb = new();
    bit                steady;
    int                sent_items;

    lzss_rgb_triplet_decoder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 250 MHz clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Both transaction monitors; an input is noted before any result at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.decode_byte(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Result side: a random stall before each transaction.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offers one input transaction; valid stays high on return for a back-to-back follow-up.
    task automatic send_item(input logic [7:0] value, input logic fresh);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: value, new_image: fresh};
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Drops valid and waits until every expected byte is out and the block is at rest.
    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write followed by a read back; junk above the register width is dropped.
    task automatic set_size(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[CFG_VAL_W-1:0] = value;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== CFG_DATA_W'(value)) begin
            $error("prdata: expected %0h, got %0h", value, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Back-reference token; mostly short distances so copies hit real history.
    task automatic send_reference(output int unsigned span);
        logic [11:0] distance;
        logic [3:0]  len;
        distance = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        len      = 4'($urandom);
        send_item({distance[3:0], len}, 1'b0);
        send_item(distance[11:4], 1'b0);
        span = (len + 1) * 3;
    endtask

    // Well-formed stream for the current size; stops at a full image or a spent budget.
    task automatic send_image();
        int unsigned total;
        int unsigned planned;
        int unsigned span;
        int          budget;
        logic [7:0]  flags;
        bit          first;
        total   = sb.image_bytes();
        planned = 0;
        budget  = 60;
        first   = 1'b1;
        while (planned < total && budget > 0) begin
            flags = 8'($urandom);
            send_item(flags, first);
            first = 1'b0;
            budget--;
            for (int k = 7; k >= 0; k--) begin
                if (planned < total) begin
                    if (flags[k]) begin
                        repeat (3) send_item(8'($urandom), 1'b0);
                        planned += 3;
                        budget  -= 3;
                    end else begin
                        send_reference(span);
                        planned += span;
                        budget  -= 2;
                    end
                end
            end
        end
    endtask

    // Random bytes with the odd restart in the middle of a token.
    task automatic send_noise();
        int count;
        count = $urandom_range(4, 12);
        for (int k = 0; k < count; k++) begin
            send_item(8'($urandom), (k == 0) || ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic pick_sizes();
        logic [12:0] w;
        logic [12:0] h;
        case ($urandom_range(0, 9))
            0: begin
                w = 13'($urandom_range(SIDE_LIMIT, 8191));
                h = 13'd1;
            end
            1: begin
                w = 13'd1;
                h = 13'($urandom_range(SIDE_LIMIT, 8191));
            end
            2: begin
                w = 13'd1;
                h = 13'd1;
            end
            default: begin
                w = 13'($urandom_range(1, 24));
                h = 13'($urandom_range(1, 6));
            end
        endcase
        set_size(REG_IMAGE_WIDTH, w);
        set_size(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin : stimulus
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        steady     = 1'b0;
        sent_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size 1x1: a reference into empty history gives zeros, cut at the end.
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b0);  // image full, ignored
        quiesce();

        // Extreme literal bytes, then an overlapping copy ending exactly at the image end.
        set_size(REG_IMAGE_WIDTH, 13'd4);
        send_item(8'h80, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h02, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hC3, 1'b0);  // image full, ignored
        quiesce();

        // Shrink inside a literal, regrow, then a literal that no longer fits.
        send_item(8'hFF, 1'b1);
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h33, 1'b0);
        send_item(8'h44, 1'b0);
        quiesce();
        set_size(REG_IMAGE_WIDTH, 13'd1);
        send_item(8'h55, 1'b0);
        send_item(8'h66, 1'b0);
        quiesce();
        set_size(REG_IMAGE_WIDTH, 13'd3);
        send_item(8'h77, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h88, 1'b0);  // only two bytes left: decoding stops
        send_item(8'h99, 1'b0);  // ignored while stopped
        quiesce();

        // Zero width leaves no room at all.
        set_size(REG_IMAGE_WIDTH, 13'd0);
        send_item(8'hFF, 1'b1);
        quiesce();

        // Oversized sides clamp; longest run from the farthest distance.
        set_size(REG_IMAGE_WIDTH, 13'h1FFF);
        set_size(REG_IMAGE_HEIGHT, 13'h1FFF);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        quiesce();

        // Random images under varying sizes and idling.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                quiesce();
                pick_sizes();
            end
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end else begin
                send_image();
            end
        end

        quiesce();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
